// ===== src/sha256_hash_engine_core_defines.svh =====
// Assertion macros used by the checker module.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed: same-cycle rule");

// Antecedent implies consequent in the following cycle.
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed: next-cycle rule");

// Expression never holds.
`define SHA_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sha256 check failed: forbidden condition");

`endif

// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps

package sha_pkg;

    localparam int NUM_ROUNDS   = 64;
    localparam int ROUND_BITS   = 6;
    localparam int DIGEST_WORDS = 8;
    localparam int OUT_IDX_BITS = 3;

    localparam logic [ROUND_BITS-1:0]   LAST_ROUND   = ROUND_BITS'(NUM_ROUNDS - 1);
    localparam logic [OUT_IDX_BITS-1:0] LAST_OUT_IDX = OUT_IDX_BITS'(DIGEST_WORDS - 1);

    localparam logic [31:0] HASH_INIT [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0c25, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                    accept;     // absorb the input item
        logic                    load;       // copy hash and block into round state
        logic                    round;      // run one compression round
        logic                    final_add;  // fold working vars into hash
        logic                    pad;        // write 0x80 marker and zero tail
        logic                    len;        // write 64-bit bit length
        logic                    clear_low;  // zero words below the length
        logic                    restart;    // reinit for next message
        logic [ROUND_BITS-1:0]   round_idx;
        logic [OUT_IDX_BITS-1:0] out_idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full_now;  // accepted item completes a 64-byte block
        logic overflow;  // padding spills into an extra block
    } status_t;

endpackage

// ===== src/sha_ctrl.sv =====
`timescale 1ns / 1ps

module sha_ctrl
    import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    last_word,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_EXTRA = 2'd1;
    localparam logic [1:0] PH_LAST  = 2'd2;

    logic [2:0]              state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    last_reg, last_next;
    logic                    over_reg, over_next;
    logic [ROUND_BITS-1:0]   round_reg, round_next;
    logic [OUT_IDX_BITS-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        last_next     = last_reg;
        over_next     = over_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.round_idx = round_reg;
        cmd.out_idx   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = last_word;
                    if (st.full_now)
                    begin
                        phase_next = PH_DATA;
                        state_next = S_LOAD;
                    end
                    else if (last_word)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.final_add = 1'b1;
                case (phase_reg)
                    PH_DATA:  state_next = last_reg ? S_PAD : S_IDLE;
                    PH_EXTRA: state_next = S_LEN;
                    default:
                    begin
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_PAD:
            begin
                cmd.pad   = 1'b1;
                over_next = st.overflow;
                if (st.overflow)
                begin
                    phase_next = PH_EXTRA;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.len       = 1'b1;
                cmd.clear_low = over_reg;
                phase_next    = PH_LAST;
                state_next    = S_LOAD;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_OUT_IDX)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            last_reg  <= 1'b0;
            over_reg  <= 1'b0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
            over_reg  <= over_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== src/sha_dp.sv =====
`timescale 1ns / 1ps

module sha_dp
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic [31:0] digest_word
);

    localparam int BLOCK_WORDS = 16;
    localparam int LEN_HI_IDX  = 14;
    localparam int LEN_LO_IDX  = 15;
    localparam logic [5:0] PAD_LIMIT = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] hash_reg [DIGEST_WORDS];
    logic [31:0] hash_next [DIGEST_WORDS];
    logic [31:0] wv_reg [DIGEST_WORDS];
    logic [31:0] wv_next [DIGEST_WORDS];
    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] win_next [BLOCK_WORDS];
    logic [31:0] buf_reg [BLOCK_WORDS];
    logic [31:0] buf_next [BLOCK_WORDS];
    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bits_reg, bits_next;

    logic [2:0]  cnt;
    logic [31:0] masked;
    logic [6:0]  bytes_sum;
    logic [3:0]  wr_idx;
    logic [3:0]  pad_idx;
    logic [31:0] pad_word;
    logic [31:0] big_s0, big_s1, ch, maj, t1, t2, new_w;

    // Clamp the byte count and drop bytes past it.
    always_comb
    begin
        cnt = (!last_word || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (cnt)
            3'd0:    masked = '0;
            3'd1:    masked = {data_word[31:24], 24'h0};
            3'd2:    masked = {data_word[31:16], 16'h0};
            3'd3:    masked = {data_word[31:8], 8'h0};
            default: masked = data_word;
        endcase
        bytes_sum   = {1'b0, bytes_reg} + {4'b0, cnt};
        wr_idx      = bytes_reg[5:2];
        pad_idx     = bytes_reg[5:2];
        st.full_now = bytes_sum[6];
        st.overflow = (bytes_reg >= PAD_LIMIT);
    end

    // Marker byte right after the last message byte.
    always_comb
    begin
        case (bytes_reg[1:0])
            2'd0:    pad_word = 32'h8000_0000;
            2'd1:    pad_word = {buf_reg[pad_idx][31:24], 8'h80, 16'h0};
            2'd2:    pad_word = {buf_reg[pad_idx][31:16], 8'h80, 8'h0};
            default: pad_word = {buf_reg[pad_idx][31:8], 8'h80};
        endcase
    end

    for (genvar g = 0; g < BLOCK_WORDS; g++)
    begin : g_buf
        always_comb
        begin
            buf_next[g] = buf_reg[g];
            if (cmd.accept && cnt != 3'd0 && wr_idx == 4'(g))
            begin
                buf_next[g] = masked;
            end
            else if (cmd.pad)
            begin
                if (pad_idx == 4'(g))
                begin
                    buf_next[g] = pad_word;
                end
                else if (4'(g) > pad_idx)
                begin
                    buf_next[g] = '0;
                end
            end
            else if (cmd.len)
            begin
                if (g == LEN_HI_IDX)
                begin
                    buf_next[g] = bits_reg[63:32];
                end
                else if (g == LEN_LO_IDX)
                begin
                    buf_next[g] = bits_reg[31:0];
                end
                else if (cmd.clear_low)
                begin
                    buf_next[g] = '0;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            buf_reg[g] <= buf_next[g];
        end
    end

    // One compression round and the next schedule word.
    always_comb
    begin
        big_s1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
        big_s0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
        ch     = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj    = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
               ^ (wv_reg[1] & wv_reg[2]);
        t1     = wv_reg[7] + big_s1 + ch + ROUND_K[cmd.round_idx] + win_reg[0];
        t2     = big_s0 + maj;
        new_w  = (rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10))
               + win_reg[9]
               + (rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3))
               + win_reg[0];
    end

    always_comb
    begin
        hash_next  = hash_reg;
        wv_next    = wv_reg;
        win_next   = win_reg;
        bytes_next = bytes_reg;
        bits_next  = bits_reg;
        if (cmd.accept)
        begin
            bytes_next = bytes_sum[5:0];
            bits_next  = bits_reg + {58'h0, cnt, 3'b000};
        end
        if (cmd.load)
        begin
            wv_next  = hash_reg;
            win_next = buf_reg;
        end
        if (cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[BLOCK_WORDS - 1] = new_w;
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end
        if (cmd.final_add)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_next[i] = hash_reg[i] + wv_reg[i];
            end
        end
        if (cmd.restart)
        begin
            hash_next  = HASH_INIT;
            bytes_next = '0;
            bits_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= HASH_INIT;
            bytes_reg <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            bytes_reg <= bytes_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        win_reg <= win_next;
    end

    assign digest_word = hash_reg[cmd.out_idx];

endmodule

// ===== src/sha256_hash_engine_core.sv =====
`timescale 1ns / 1ps
// SHA-256 hash engine.
// Input channel (in_valid/in_ready): one item carries data_word (big-endian,
// first byte in bits 31:24), valid_bytes and last_word. Only the last item of
// a message may carry fewer than four bytes; earlier items count as four.
// Output channel (out_valid/out_ready): eight items per message, digest_word
// with word_index 0 (most significant) to 7, digest_end high on index 7.
// An item that does not fill the 64-byte block is only stored in the block buffer.
// An item that fills a block starts its compression (load, 64 rounds at one round
// per cycle in the shared round unit, hash update). A last item adds a pad
// step, a length step and the compression of the final block, plus one more
// block when the pad marker lands in bytes 56..63 of a block.
// The block works on one item at a time: in_ready is high only while idle,
// and stays low while the digest is being delivered.
// Stalls: while out_ready is low, hold the current digest item unchanged.
// After the eighth item is taken the engine reinitializes and takes the next
// message in the following cycle.
// Reset: rst_n clears control, loads the initial hash values, zeroes the byte
// and bit counters; the engine is ready right after reset.

module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_end
);

    cmd_t    cmd;
    status_t st;

    // Sequencer: absorb, compress, pad, emit.
    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_word (last_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Block buffer, message schedule, round unit and hash state.
    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .digest_word (digest_word)
    );

    // Index and end mark follow the output word counter.
    assign word_index = cmd.out_idx;
    assign digest_end = (cmd.out_idx == LAST_OUT_IDX);

endmodule

// ===== src/sha_chk.sv =====
`timescale 1ns / 1ps
`include "sha256_hash_engine_core_defines.svh"

module sha_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        digest_end
);

    // Never take input while the digest is out.
    `SHA_ASSERT_NEVER(a_no_overlap, in_ready && out_valid)

    // Hold a stalled digest item.
    `SHA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))

    // Advance the word index within one digest.
    `SHA_ASSERT_NEXT(a_advance, out_valid && out_ready && !digest_end, out_valid && word_index == $past(word_index) + 3'd1)

    // Drop back to idle right after the final word.
    `SHA_ASSERT_NEXT(a_back_idle, out_valid && out_ready && digest_end, in_ready && !out_valid)

endmodule

bind sha256_hash_engine_core sha_chk u_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Message words reach the engine through a queue that the stimulus block fills.
    typedef struct {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        fin;
    } msg_item_t;

    // One digest word as it should leave the engine.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_item_t;

    // Traffic phases; each one sets how often the two sides idle.
    typedef enum logic [2:0] {
        PH_DIRECTED,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_HOLD
    } phase_t;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 300;

    // Initial hash value and round constants, kept apart from the design's own tables.
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0c25, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] data_word = '0;
    logic [2:0]  valid_bytes = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;

    // Stimulus and expectations.
    msg_item_t    word_q[$];
    digest_item_t digest_q[$];

    // Running hash of the message being absorbed.
    logic [31:0] hash_state [8];
    logic [31:0] blk [16];
    int unsigned blk_bytes;
    logic [63:0] msg_bits;

    // Traffic knobs, written by the stimulus block at the falling edge.
    phase_t phase = PH_DIRECTED;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    // Long output hold-off, counted in its own process.
    int     hold_left = 0;
    logic   hold_done = 1'b0;

    int mismatches = 0;
    int items_taken = 0;
    int msgs_taken = 0;
    int words_seen = 0;
    int cycle_count = 0;

    digest_item_t want;

    sha256_hash_engine_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_end  (digest_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the 64-byte block in blk into hash_state: expand the schedule, run
    // the 64 rounds, add the working variables back.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w[t] = blk[t];
            else
            begin
                s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
        end
        v = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int k = 7; k > 0; k--)
                v[k] = v[k-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] = hash_state[k] + v[k];
    endtask

    task automatic start_digest();
        hash_state = SHA_IV;
        blk_bytes = 0;
        msg_bits = '0;
    endtask

    // Absorb one accepted item; on the last one pad, finish, and queue the
    // eight digest words the engine must deliver.
    task automatic sha_absorb(input logic [31:0] dw, input logic [2:0] nb, input logic fin);
        int unsigned cnt;
        int unsigned pos;
        int unsigned idx;
        int unsigned off;
        logic [31:0] d;
        digest_item_t item;
        // Short counts only count on the last item; anything above four saturates.
        cnt = (!fin || nb > 3'd4) ? 4 : nb;
        d = dw;
        if (cnt < 4)
            d = d & ~(32'hffffffff >> (8 * cnt));
        if (cnt > 0)
        begin
            blk[blk_bytes >> 2] = d;
            blk_bytes += cnt;
            msg_bits += 64'(8 * cnt);
            if (blk_bytes >= 64)
            begin
                compress_block();
                blk_bytes = 0;
            end
        end
        if (!fin)
            return;
        pos = blk_bytes;
        idx = pos >> 2;
        off = pos & 3;
        if (off == 0)
            blk[idx] = 32'h80000000;
        else
            blk[idx] = (blk[idx] & ~(32'hffffffff >> (8 * off))) | (32'h80 << (24 - 8 * off));
        for (int k = idx + 1; k < 16; k++)
            blk[k] = '0;
        // Marker in the length field: spill into one more block.
        if (pos + 1 > 56)
        begin
            compress_block();
            for (int k = 0; k < 16; k++)
                blk[k] = '0;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress_block();
        for (int k = 0; k < 8; k++)
        begin
            item.word = hash_state[k];
            item.idx = 3'(k);
            item.fin = (k == 7);
            digest_q.push_back(item);
        end
        start_digest();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("error at cycle %0d: %s got %h, want %h", cycle_count, what, got, exp_val);
        mismatches++;
    endtask

    // Driver: predict on every accepted item, then load the next one unless
    // this cycle is picked as idle. Hold the payload while in_ready is low.
    always @(posedge clk)
    begin : feed
        msg_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                sha_absorb(data_word, valid_bytes, last_word);
                items_taken++;
                if (last_word)
                    msgs_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = word_q.pop_front();
                    in_valid <= 1'b1;
                    data_word <= nxt.data;
                    valid_bytes <= nxt.nbytes;
                    last_word <= nxt.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Arm the long hold-off once, on entry to the hold phase, then count it down.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (phase == PH_HOLD && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: stall at the phase's rate, and all the time during the hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0 || (phase == PH_HOLD && !hold_done))
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare every digest word taken with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest_word", digest_word, '0);
            else
            begin
                want = digest_q.pop_front();
                if (digest_word !== want.word)
                    report_mismatch("digest_word", digest_word, want.word);
                if (word_index !== want.idx)
                    report_mismatch("word_index", 32'(word_index), 32'(want.idx));
                if (digest_end !== want.fin)
                    report_mismatch("digest_end", 32'(digest_end), 32'(want.fin));
            end
        end
    end

    // Give up on a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, digest_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(input logic [31:0] d, input logic [2:0] nb, input logic fin);
        msg_item_t it;
        it.data = d;
        it.nbytes = nb;
        it.fin = fin;
        word_q.push_back(it);
    endtask

    // One message of nwords items with random content; earlier items mostly
    // carry four bytes, the last one any count from zero up to seven.
    task automatic queue_message(input int nwords);
        logic [31:0] d;
        logic [2:0]  nb;
        logic        fin;
        int          pick;
        for (int i = 0; i < nwords; i++)
        begin
            fin = (i == nwords - 1);
            if (fin || $urandom_range(99) < 20)
                nb = 3'($urandom_range(7, 0));
            else
                nb = 3'd4;
            pick = $urandom_range(99);
            if (pick < 5)
                d = '0;
            else if (pick < 10)
                d = '1;
            else
                d = $urandom;
            add_item(d, nb, fin);
        end
    endtask

    // Lengths around the one- and two-block padding boundaries, a few long
    // messages, and short ones for about the other half.
    task automatic queue_random_traffic(input int n_items);
        int added;
        int nwords;
        int pick;
        added = 0;
        while (added < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                nwords = $urandom_range(17, 12);
            else if (pick < 45)
                nwords = $urandom_range(33, 28);
            else if (pick < 50)
                nwords = $urandom_range(48, 34);
            else
                nwords = $urandom_range(11, 1);
            queue_message(nwords);
            added += nwords;
        end
    endtask

    // Hold the sender until everything queued has been sent and every digest has come back.
    task automatic wait_drained();
        while (word_q.size() != 0 || in_valid || digest_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input phase_t ph, input int idle_pct, input int stall_pct,
                             input int n_items);
        @(negedge clk);
        phase = ph;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_traffic(n_items);
        wait_drained();
    endtask

    initial
    begin
        for (int k = 0; k < 16; k++)
            blk[k] = '0;
        start_digest();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cases, no idling.
        @(negedge clk);
        // Empty message; the stray data bytes must be ignored.
        add_item(32'hdeadbeef, 3'd0, 1'b1);
        // "abc" with a junk fourth byte.
        add_item(32'h616263ff, 3'd3, 1'b1);
        // Count above four on the last item saturates.
        add_item(32'h01234567, 3'd7, 1'b1);
        // Short counts on earlier items still count as four bytes.
        add_item(32'hffffffff, 3'd0, 1'b0);
        add_item(32'h00000000, 3'd1, 1'b0);
        add_item(32'h12345678, 3'd1, 1'b1);
        // Exactly one full block: padding goes into a block of its own.
        for (int i = 0; i < 16; i++)
            add_item((i < 8) ? 32'hffffffff : 32'h00000000, 3'd4, i == 15);
        wait_drained();

        // Random traffic under each idling pattern, draining between phases.
        run_phase(PH_FREE,       0,  0,  50);
        run_phase(PH_SEND_IDLE,  84, 0,  35);
        run_phase(PH_RECV_STALL, 0,  84, 50);
        run_phase(PH_BOTH,       11, 11, 65);
        // Receiver holds off long enough for the engine to back up onto the sender.
        run_phase(PH_HOLD,       0,  0,  35);
        run_phase(PH_FREE,       0,  0,  20);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d messages in %0d input items, %0d digest words checked",
                 msgs_taken, items_taken, words_seen);
        $display("traffic ran free, with a sparse sender, a stalling receiver, mixed idling "
                 , "and a long output hold-off");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
